FILE: design/bhcd_pkg.sv
package bhcd_pkg;

	localparam int BUTTON_COUNT_DEF = 6;
	localparam int BUTTONS_WIDTH    = 6;
	localparam int COUNT_WIDTH      = 16;
	localparam int BUTTON_NUM_WIDTH = 3;
	localparam int KIND_WIDTH       = 2;
	localparam int CFG_INDEX_WIDTH  = 1;
	localparam int CFG_DATA_WIDTH   = 16;

	localparam logic [COUNT_WIDTH-1:0] HOLD_THRESHOLD_RESET = 16'd100;
	localparam logic COMBINATION_MODE_RESET = 1'b1;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_THRESHOLD   = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMBINATION_MODE = 1'd1;

	localparam logic [KIND_WIDTH-1:0] EV_NONE   = 2'd0;
	localparam logic [KIND_WIDTH-1:0] EV_SINGLE = 2'd1;
	localparam logic [KIND_WIDTH-1:0] EV_PAIR   = 2'd2;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef struct packed {
		count_t hold_threshold;
		logic   combination_mode;
	} cfg_t;

	typedef struct packed {
		logic [KIND_WIDTH-1:0]       event_kind;
		logic [BUTTON_NUM_WIDTH-1:0] first_button;
		logic [BUTTON_NUM_WIDTH-1:0] second_button;
	} result_t;

endpackage

FILE: design/bhcd_item_if.sv
interface bhcd_item_if;
	logic                               valid;
	logic                               ready;
	logic [bhcd_pkg::BUTTONS_WIDTH-1:0] buttons_down;
	logic                               clear_timings;

	modport source(output valid, output buttons_down, output clear_timings, input ready);
	modport sink(input valid, input buttons_down, input clear_timings, output ready);
endinterface

FILE: design/bhcd_result_if.sv
interface bhcd_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [bhcd_pkg::KIND_WIDTH-1:0]       event_kind;
	logic [bhcd_pkg::BUTTON_NUM_WIDTH-1:0] first_button;
	logic [bhcd_pkg::BUTTON_NUM_WIDTH-1:0] second_button;

	modport source(output valid, output event_kind, output first_button, output second_button,
		input ready);
	modport sink(input valid, input event_kind, input first_button, input second_button,
		output ready);
endinterface

FILE: design/bhcd_scan.sv
module bhcd_scan #(
	parameter int BUTTON_COUNT = bhcd_pkg::BUTTON_COUNT_DEF
) (
	input  logic [BUTTON_COUNT-1:0] levels,
	input  logic                    clear_timings,
	input  bhcd_pkg::cfg_t          cfg,
	input  bhcd_pkg::count_t        counts [BUTTON_COUNT],
	input  logic [BUTTON_COUNT-1:0] held,
	input  logic                    combo,
	output bhcd_pkg::count_t        counts_next [BUTTON_COUNT],
	output logic [BUTTON_COUNT-1:0] held_next,
	output logic                    combo_next,
	output bhcd_pkg::result_t       res
);

	localparam int IdxW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int NumW = bhcd_pkg::BUTTON_NUM_WIDTH;

	logic                   low0_found, low1_found;
	logic [IdxW-1:0]        low0, low1;
	logic                   stopped, pair_sel, rel_sel;
	logic [IdxW-1:0]        ev_idx, partner_sel;
	logic                   partner_ok;
	logic [IdxW-1:0]        partner;
	bhcd_pkg::count_t       cand_cnt, cnt_inc;
	logic                   cand_held, ev, ev_pair, ev_rel;

	always_comb begin
		low0_found  = 1'b0;
		low1_found  = 1'b0;
		low0        = '0;
		low1        = '0;
		stopped     = 1'b0;
		pair_sel    = 1'b0;
		rel_sel     = 1'b0;
		ev_idx      = '0;
		partner_sel = '0;
		partner_ok  = 1'b0;
		partner     = '0;
		cand_cnt    = '0;
		cnt_inc     = '0;
		cand_held   = 1'b0;
		ev          = 1'b0;
		ev_pair     = 1'b0;
		ev_rel      = 1'b0;
		counts_next = counts;
		held_next   = held;
		combo_next  = combo;
		res         = '0;

		for (int k = 0; k < BUTTON_COUNT; k++) begin
			if (levels[k]) begin
				priority if (!low0_found) begin
					low0       = IdxW'(k);
					low0_found = 1'b1;
				end else if (!low1_found) begin
					low1       = IdxW'(k);
					low1_found = 1'b1;
				end else begin
				end
			end
		end

		for (int k = 0; k < BUTTON_COUNT; k++) begin
			priority if (low0_found && low0 != IdxW'(k)) begin
				partner_ok = 1'b1;
				partner    = low0;
			end else if (low0_found && low1_found) begin
				partner_ok = 1'b1;
				partner    = low1;
			end else begin
				partner_ok = 1'b0;
				partner    = '0;
			end

			cnt_inc   = counts[k] + bhcd_pkg::COUNT_WIDTH'(1);
			cand_cnt  = counts[k];
			cand_held = held[k];
			ev        = 1'b0;
			ev_pair   = 1'b0;
			ev_rel    = 1'b0;

			if (cfg.combination_mode) begin
				priority if (held[k]) begin
					priority if (partner_ok) begin
						ev      = 1'b1;
						ev_pair = 1'b1;
					end else if (!levels[k]) begin
						cand_cnt  = '0;
						cand_held = 1'b0;
						ev        = 1'b1;
						ev_rel    = 1'b1;
					end else begin
					end
				end else if (levels[k]) begin
					if (cnt_inc == cfg.hold_threshold) begin
						cand_cnt  = '0;
						cand_held = 1'b1;
						ev        = 1'b1;
					end else begin
						cand_cnt = cnt_inc;
					end
				end else begin
					cand_cnt = '0;
				end
			end else begin
				if (levels[k]) begin
					if (!held[k]) begin
						if (cnt_inc == cfg.hold_threshold) begin
							cand_cnt  = '0;
							cand_held = 1'b1;
							ev        = 1'b1;
						end else begin
							cand_cnt = cnt_inc;
						end
					end
				end else begin
					cand_cnt  = '0;
					cand_held = 1'b0;
				end
			end

			if (!stopped) begin
				counts_next[k] = cand_cnt;
				held_next[k]   = cand_held;
				if (ev) begin
					stopped     = 1'b1;
					ev_idx      = IdxW'(k);
					pair_sel    = ev_pair;
					rel_sel     = ev_rel;
					partner_sel = partner;
				end
			end
		end

		if (stopped) begin
			priority if (pair_sel) begin
				counts_next[partner_sel] = '0;
				held_next[partner_sel]   = 1'b0;
				combo_next               = 1'b1;
				res.event_kind           = bhcd_pkg::EV_PAIR;
				res.first_button         = NumW'(ev_idx) + NumW'(1);
				res.second_button        = NumW'(partner_sel) + NumW'(1);
			end else if (rel_sel) begin
				if (combo) begin
					combo_next = 1'b0;
				end else begin
					res.event_kind   = bhcd_pkg::EV_SINGLE;
					res.first_button = NumW'(ev_idx) + NumW'(1);
				end
			end else if (!cfg.combination_mode) begin
				res.event_kind   = bhcd_pkg::EV_SINGLE;
				res.first_button = NumW'(ev_idx) + NumW'(1);
			end else begin
			end
		end

		if (clear_timings) begin
			for (int k = 0; k < BUTTON_COUNT; k++) begin
				counts_next[k] = '0;
			end
			held_next  = '0;
			combo_next = combo;
			res        = '0;
		end
	end

endmodule

FILE: design/button_hold_combination_detector_core.sv
// A word accepted on the item channel is registered into stage s1, scanned
// there, and its result is registered and offered on the result channel.
// Throughput: one word per cycle while the result channel is not stalled.
// Reset (arst_n low, asynchronous): counters, held marks and the combo flag
// clear, threshold returns to 100, combination mode to on, both channels empty.
module button_hold_combination_detector_core #(
	parameter int BUTTON_COUNT = bhcd_pkg::BUTTON_COUNT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [bhcd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [bhcd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	bhcd_item_if.sink                             item,
	bhcd_result_if.source                         result
);

	localparam int WideW = BUTTON_COUNT + bhcd_pkg::BUTTONS_WIDTH;

	bhcd_pkg::cfg_t             cfg_q;
	bhcd_pkg::count_t           cnt_q [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0]    held_q;
	logic                       combo_q;

	logic                                valid_s1;
	logic [bhcd_pkg::BUTTONS_WIDTH-1:0]  buttons_s1;
	logic                                clear_s1;

	logic                       res_valid_q;
	bhcd_pkg::result_t          res_q;

	logic                       take_s1;
	logic [WideW-1:0]           wide_levels;
	logic [BUTTON_COUNT-1:0]    levels;
	bhcd_pkg::count_t           cnt_next [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0]    held_next;
	logic                       combo_next;
	bhcd_pkg::result_t          res_next;
	logic                       held_count_bad;

	assign take_s1     = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready  = !valid_s1 || take_s1;
	assign wide_levels = WideW'(buttons_s1);
	assign levels      = wide_levels[BUTTON_COUNT-1:0];

	bhcd_scan #(
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_scan (
		.levels        (levels),
		.clear_timings (clear_s1),
		.cfg           (cfg_q),
		.counts        (cnt_q),
		.held          (held_q),
		.combo         (combo_q),
		.counts_next   (cnt_next),
		.held_next     (held_next),
		.combo_next    (combo_next),
		.res           (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_threshold   <= bhcd_pkg::HOLD_THRESHOLD_RESET;
			cfg_q.combination_mode <= bhcd_pkg::COMBINATION_MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bhcd_pkg::CFG_HOLD_THRESHOLD: begin
					cfg_q.hold_threshold <= cfg_data;
				end
				bhcd_pkg::CFG_COMBINATION_MODE: begin
					cfg_q.combination_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BUTTON_COUNT; k++) begin
				cnt_q[k] <= '0;
			end
			held_q  <= '0;
			combo_q <= 1'b0;
		end else if (take_s1) begin
			cnt_q   <= cnt_next;
			held_q  <= held_next;
			combo_q <= combo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			buttons_s1 <= item.buttons_down;
			clear_s1   <= item.clear_timings;
		end
		if (take_s1) begin
			res_q <= res_next;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.event_kind    = res_q.event_kind;
	assign result.first_button  = res_q.first_button;
	assign result.second_button = res_q.second_button;

	always_comb begin
		held_count_bad = 1'b0;
		for (int k = 0; k < BUTTON_COUNT; k++) begin
			if (held_q[k] && cnt_q[k] != '0) begin
				held_count_bad = 1'b1;
			end
		end
	end

	a_held_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!held_count_bad)
		else $error("held button has a running count");

	a_clear_drops_held: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && clear_s1 |=> held_q == '0)
		else $error("clear left a held mark");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.event_kind == bhcd_pkg::EV_NONE ||
			res_q.event_kind == bhcd_pkg::EV_SINGLE ||
			res_q.event_kind == bhcd_pkg::EV_PAIR))
		else $error("illegal event kind");

	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.event_kind == bhcd_pkg::EV_NONE |->
			res_q.first_button == '0 && res_q.second_button == '0)
		else $error("empty event carries button numbers");

endmodule

FILE: dv/bhcd_event_checker.sv
module bhcd_event_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bhcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [bhcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	bhcd_item_if                                 item,
	bhcd_result_if                               result,
	output int                                   fail_count,
	output int                                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = bhcd_pkg::BUTTON_COUNT_DEF;

	bhcd_pkg::count_t  hold_cnt [NB];
	logic              held [NB];
	logic              pair_seen;
	bhcd_pkg::count_t  threshold;
	logic              pair_mode;
	bhcd_pkg::result_t expected_events [$];
	bhcd_pkg::result_t want;

	function automatic logic count_hold(input int k);
		hold_cnt[k] = hold_cnt[k] + 1'b1;
		if (hold_cnt[k] == threshold) begin
			hold_cnt[k] = '0;
			held[k] = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void clear_holds();
		for (int k = 0; k < NB; k++) begin
			hold_cnt[k] = '0;
			held[k] = 1'b0;
		end
	endfunction

	function automatic bhcd_pkg::result_t scan_poll(
		input logic [bhcd_pkg::BUTTONS_WIDTH-1:0] levels, input logic clr);
		bhcd_pkg::result_t r;
		r = '0;
		r.event_kind = bhcd_pkg::EV_NONE;
		if (clr) begin
			clear_holds();
			return r;
		end
		if (!pair_mode) begin
			for (int k = 0; k < NB; k++) begin
				if (!levels[k]) begin
					hold_cnt[k] = '0;
					held[k] = 1'b0;
				end else if (!held[k]) begin
					if (count_hold(k)) begin
						r.event_kind = bhcd_pkg::EV_SINGLE;
						r.first_button = bhcd_pkg::BUTTON_NUM_WIDTH'(k + 1);
						return r;
					end
				end
			end
			return r;
		end
		for (int k = 0; k < NB; k++) begin
			if (held[k]) begin
				for (int m = 0; m < NB; m++) begin
					if (m != k && levels[m]) begin
						hold_cnt[m] = '0;
						held[m] = 1'b0;
						pair_seen = 1'b1;
						r.event_kind = bhcd_pkg::EV_PAIR;
						r.first_button = bhcd_pkg::BUTTON_NUM_WIDTH'(k + 1);
						r.second_button = bhcd_pkg::BUTTON_NUM_WIDTH'(m + 1);
						return r;
					end
				end
				if (!levels[k]) begin
					hold_cnt[k] = '0;
					held[k] = 1'b0;
					// swallow the release that follows a reported pair
					if (pair_seen) begin
						pair_seen = 1'b0;
						return r;
					end
					r.event_kind = bhcd_pkg::EV_SINGLE;
					r.first_button = bhcd_pkg::BUTTON_NUM_WIDTH'(k + 1);
					return r;
				end
			end else if (levels[k]) begin
				if (count_hold(k))
					return r;
			end else begin
				hold_cnt[k] = '0;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			fail_count++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = bhcd_pkg::HOLD_THRESHOLD_RESET;
			pair_mode = bhcd_pkg::COMBINATION_MODE_RESET;
			clear_holds();
			pair_seen = 1'b0;
			expected_events.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bhcd_pkg::CFG_HOLD_THRESHOLD: threshold = cfg_data;
					bhcd_pkg::CFG_COMBINATION_MODE: pair_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (item.valid && item.ready)
				expected_events.push_back(scan_poll(item.buttons_down, item.clear_timings));
			if (result.valid && result.ready) begin
				if (expected_events.size() == 0) begin
					fail_count++;
					$display("%0t: expected no word, got kind %0d first %0d second %0d",
						$time, result.event_kind, result.first_button,
						result.second_button);
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", int'(want.event_kind),
						int'(result.event_kind));
					check_field("first_button", int'(want.first_button),
						int'(result.first_button));
					check_field("second_button", int'(want.second_button),
						int'(result.second_button));
				end
			end
			outstanding = expected_events.size();
		end
	end

endmodule

FILE: dv/tb_button_hold_combination_detector_core.sv
module tb_button_hold_combination_detector_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_we;
	logic [bhcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [bhcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;
	int                                   fail_count;
	int                                   outstanding;
	int                                   cycles;
	int                                   cur_thr;
	logic                                 calm;

	bhcd_item_if   item_ch();
	bhcd_result_if result_ch();

	button_hold_combination_detector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	bhcd_event_checker event_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_gap(input logic quiet);
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [bhcd_pkg::BUTTONS_WIDTH-1:0] pick_levels();
		logic [bhcd_pkg::BUTTONS_WIDTH-1:0] lv;
		logic [2:0]                         pos;
		int                                 roll;
		lv = '0;
		roll = $urandom_range(0, 9);
		if (roll >= 3) begin
			pos = 3'($urandom_range(0, bhcd_pkg::BUTTONS_WIDTH-1));
			lv[pos] = 1'b1;
		end
		if (roll >= 7) begin
			pos = 3'($urandom_range(0, bhcd_pkg::BUTTONS_WIDTH-1));
			lv[pos] = 1'b1;
		end
		if (roll == 9)
			lv = bhcd_pkg::BUTTONS_WIDTH'($urandom);
		return lv;
	endfunction

	task automatic send_poll(input logic [bhcd_pkg::BUTTONS_WIDTH-1:0] levels,
		input logic clr);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.buttons_down <= levels;
		item_ch.clear_timings <= clr;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [bhcd_pkg::CFG_INDEX_WIDTH-1:0] index,
		input int value);
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= bhcd_pkg::CFG_DATA_WIDTH'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input int thr, input logic mode);
		write_reg(bhcd_pkg::CFG_HOLD_THRESHOLD, thr);
		write_reg(bhcd_pkg::CFG_COMBINATION_MODE, int'(mode));
		cur_thr = thr;
	endtask

	task automatic run_polls(input int n);
		int                                 sent;
		int                                 len;
		logic [2:0]                         flip;
		logic [bhcd_pkg::BUTTONS_WIDTH-1:0] lv;
		sent = 0;
		lv = '0;
		while (sent < n) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 24) == 0) begin
				send_poll(bhcd_pkg::BUTTONS_WIDTH'($urandom), 1'b1);
				sent++;
			end else begin
				if ($urandom_range(0, 2) == 0) begin
					lv = pick_levels();
				end else begin
					flip = 3'($urandom_range(0, bhcd_pkg::BUTTONS_WIDTH-1));
					lv[flip] = ~lv[flip];
				end
				len = $urandom_range(1, (cur_thr < 16) ? 2 * cur_thr + 3 : 40);
				repeat (len) begin
					if ($urandom_range(0, 11) == 0) begin
						flip = 3'($urandom_range(0, bhcd_pkg::BUTTONS_WIDTH-1));
						lv[flip] = ~lv[flip];
					end
					send_poll(lv, 1'b0);
					sent++;
				end
			end
		end
	endtask

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall = pick_gap($urandom_range(0, 4) == 0);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		calm = 1'b0;
		cur_thr = 100;
		item_ch.valid = 1'b0;
		item_ch.buttons_down = '0;
		item_ch.clear_timings = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// hold one button through the default threshold, then release it
		repeat (100) send_poll(6'h04, 1'b0);
		send_poll(6'h00, 1'b0);

		set_config(2, 1'b1);
		send_poll(6'h3F, 1'b1);
		repeat (2) send_poll(6'h01, 1'b0);
		send_poll(6'h01, 1'b0);
		send_poll(6'h21, 1'b0);
		send_poll(6'h00, 1'b0);
		repeat (2) send_poll(6'h01, 1'b0);
		send_poll(6'h00, 1'b0);
		repeat (2) send_poll(6'h20, 1'b0);
		send_poll(6'h21, 1'b0);
		send_poll(6'h20, 1'b0);
		send_poll(6'h00, 1'b0);
		repeat (2) send_poll(6'h02, 1'b0);
		send_poll(6'h3F, 1'b1);
		send_poll(6'h00, 1'b0);

		set_config(1, 1'b0);
		repeat (7) send_poll(6'h3F, 1'b0);
		send_poll(6'h00, 1'b0);

		set_config(1, 1'b0);
		run_polls(250);
		set_config(1, 1'b1);
		run_polls(300);
		set_config(2, 1'b1);
		run_polls(350);
		set_config(3, 1'b0);
		run_polls(250);
		set_config(5, 1'b1);
		run_polls(350);
		set_config(4, 1'b0);
		run_polls(200);
		set_config(65535, 1'b1);
		run_polls(150);
		set_config(2, 1'b1);
		run_polls(150);

		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
